// ===== hdl/thi_pkg.sv =====
// ----------------------------------------------------------------------------
// thi_pkg
// shared item types, register indexes and constants of the terrain height
// interpolator
// ----------------------------------------------------------------------------
package thi_pkg;

    // one input item: a sample load or a height query
    typedef struct packed {
        logic        func;
        logic [15:0] sample_index;
        logic [7:0]  sample_height;
        logic [15:0] query_x;
        logic [15:0] query_z;
    } in_item_t;

    // one result item
    typedef struct packed {
        logic [24:0] height_out;
        logic        outside;
    } out_item_t;

    // configuration register indexes
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_COLUMNS = 2'd0;
    localparam cfg_index_t CFG_ROWS    = 2'd1;
    localparam cfg_index_t CFG_GAIN    = 2'd2;

    localparam logic [8:0]  COLUMNS_RESET = 9'd256;
    localparam logic [8:0]  ROWS_RESET    = 9'd256;
    localparam logic [15:0] GAIN_RESET    = 16'd256;

    // func codes
    localparam logic FUNC_LOAD = 1'b0;

    // 0.9 in Q.8, truncated
    localparam logic [24:0] HEIGHT_OFFSET = 25'd230;

    // corner read steps of a query
    typedef logic [1:0] step_t;
    localparam step_t STEP_FIRST = 2'd0;
    localparam step_t STEP_MID   = 2'd1;
    localparam step_t STEP_LAST  = 2'd2;

    // decoded item, locate stage to issue stage
    typedef struct packed {
        logic is_load;
        logic write_ok;
        logic outside;
        logic lower;
    } loc_flags_t;

    // read tag, read stage to blend unit
    typedef struct packed {
        logic valid;
        logic read;
        logic last;
        logic outside;
    } blend_ctl_t;

endpackage

// ===== hdl/thi_mem.sv =====
// ----------------------------------------------------------------------------
// thi_mem
// single-port height sample memory, one access a cycle, registered read data
// ----------------------------------------------------------------------------
module thi_mem #(
    parameter int ADDR_W = 16,
    parameter int DEPTH  = 65536
) (
    input  logic              clk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [7:0]        wdata,
    output logic [7:0]        rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/thi_locate.sv =====
// ----------------------------------------------------------------------------
// thi_locate
// decodes one item: edge test, cell base address, triangle choice and
// the three corner weights
// ----------------------------------------------------------------------------
module thi_locate #(
    parameter int FRACTION_BITS = 8,
    parameter int ADDR_W        = 16,
    parameter int STORE_DEPTH   = 65536
) (
    input  thi_pkg::in_item_t   item,
    input  logic [8:0]          cols,
    input  logic [8:0]          rows,
    output thi_pkg::loc_flags_t flags,
    output logic [ADDR_W-1:0]   base,
    output logic [ADDR_W-1:0]   load_addr,
    output logic [FRACTION_BITS:0] w0,
    output logic [FRACTION_BITS:0] w1,
    output logic [FRACTION_BITS:0] w2
);
    import thi_pkg::*;

    localparam int F  = FRACTION_BITS;
    localparam int IW = 17 - F;         // integer part of a coordinate, one spare bit
    localparam int WW = F + 1;
    localparam int EW = 9 + 16;         // grid size shifted by up to the coordinate width
    localparam int MW = IW + 11;
    localparam logic [WW-1:0] ONE = WW'(2 ** F);

    logic [16:0]    xe;
    logic [16:0]    ze;
    logic [IW-1:0]  ix;
    logic [IW-1:0]  zi;
    logic [F-1:0]   dx;
    logic [F-1:0]   zf;
    logic [IW:0]    cz;
    logic [WW-1:0]  dz;
    logic [WW-1:0]  dsum;
    logic [EW-1:0]  x_lim;
    logic [EW-1:0]  z_lim;
    logic [MW-1:0]  prod;
    logic           lower;
    logic           outside;

    always_comb
    begin
        xe = {1'b0, item.query_x};
        ze = {1'b0, item.query_z};
        ix = xe[16:F];
        zi = ze[16:F];
        dx = xe[F-1:0];
        zf = ze[F-1:0];

        // row index rounds up, dz measured down from it
        cz = {1'b0, zi} + (IW+1)'(zf != '0);
        dz = (zf == '0) ? '0 : ONE - WW'(zf);

        dsum  = WW'(dx) + dz;
        lower = dsum < ONE;

        x_lim = EW'(cols - 9'd1) << F;
        z_lim = EW'(rows - 9'd1) << F;
        outside = (cols < 9'd2) || (rows < 9'd2) ||
                  (item.query_x == '0) || (item.query_z == '0) ||
                  (EW'(item.query_x) >= x_lim) || (EW'(item.query_z) >= z_lim);

        prod = MW'(cz) * MW'(cols) + MW'(ix);
        base = ADDR_W'(prod);

        w0 = lower ? ONE - dsum : dsum - ONE;
        w1 = lower ? dz : ONE - dz;
        w2 = lower ? WW'(dx) : ONE - WW'(dx);

        load_addr      = ADDR_W'(item.sample_index);
        flags.is_load  = item.func == FUNC_LOAD;
        flags.write_ok = 32'(item.sample_index) < STORE_DEPTH;
        flags.outside  = outside;
        flags.lower    = lower;
    end

endmodule

// ===== hdl/thi_blend.sv =====
// ----------------------------------------------------------------------------
// thi_blend
// weighted corner accumulator, gain multiply and result register
// ----------------------------------------------------------------------------
module thi_blend #(
    parameter int FRACTION_BITS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  thi_pkg::blend_ctl_t    ctl,
    input  logic [7:0]             rdata,
    input  logic [FRACTION_BITS:0] weight,
    input  logic [15:0]            gain,
    output logic                   take_last,
    output logic                   res_valid,
    input  logic                   res_stall,
    output thi_pkg::out_item_t     res
);
    import thi_pkg::*;

    localparam int F  = FRACTION_BITS;
    localparam int HW = 8 + F;          // weights sum to one, so the blend stays below 256
    localparam int PW = 16 + HW;

    logic [HW-1:0] prod;
    logic [HW-1:0] acc_reg;
    logic [HW-1:0] fin_sum_reg;
    logic          fin_outside_reg;
    logic          fin_valid_reg;
    logic          fin_valid_next;
    logic [PW-1:0] mul_reg;
    logic          mul_outside_reg;
    logic          mul_valid_reg;
    logic          mul_valid_next;
    logic          res_valid_reg;
    logic          res_valid_next;
    out_item_t     res_reg;
    logic          out_free;
    logic          mul_free;
    logic          mul_move;
    logic          fin_move;

    always_comb
    begin
        prod = ctl.read ? HW'(rdata) * HW'(weight) : '0;

        out_free  = !res_valid_reg || !res_stall;
        mul_move  = mul_valid_reg && out_free;
        mul_free  = !mul_valid_reg || out_free;
        fin_move  = fin_valid_reg && mul_free;
        take_last = !fin_valid_reg || mul_free;

        fin_valid_next = (ctl.valid && ctl.last) || (fin_valid_reg && !fin_move);
        mul_valid_next = fin_move || (mul_valid_reg && !mul_move);
        res_valid_next = mul_move || (res_valid_reg && res_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            fin_valid_reg <= 1'b0;
            mul_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.valid)
            begin
                acc_reg <= ctl.last ? '0 : acc_reg + prod;
            end
            fin_valid_reg <= fin_valid_next;
            mul_valid_reg <= mul_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.valid && ctl.last)
        begin
            fin_sum_reg     <= acc_reg + prod;
            fin_outside_reg <= ctl.outside;
        end
        if (fin_move)
        begin
            mul_reg         <= PW'(gain) * PW'(fin_sum_reg);
            mul_outside_reg <= fin_outside_reg;
        end
        if (mul_move)
        begin
            res_reg.height_out <= 25'(mul_reg[PW-1:F]) + HEIGHT_OFFSET;
            res_reg.outside    <= mul_outside_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== hdl/terrain_height_interpolator_unit.sv =====
// ----------------------------------------------------------------------------
// terrain_height_interpolator_unit
// heightmap sampler: loads 8-bit height samples and returns interpolated
// triangle heights, scaled and offset, in Q.8
// ----------------------------------------------------------------------------
// The grid lives in one single-port synchronous memory of
// MAX_COLUMNS*MAX_ROWS bytes, loaded one sample per load item; its contents
// are undefined until written, and a query must only touch written samples.
// Every item passes a locate register, then an issue stage that owns the
// memory port. A load takes the port for its write and gives no result. A
// query takes it for one read per triangle corner, and the locate register
// takes the next item meanwhile; loads go one every cycle unless held behind
// a stalled query, and a query on or beyond the grid edge needs no reads. A
// result passes the locate register, the issue stage, the corner reads
// ending in the final sum, the gain multiply and the result register, and an
// edge query the same stages without reads. Items are served strictly in
// order through the one port, so a query sees every load accepted before it.
// Grid size registers above the MAX_* parameters saturate to them. Write
// configuration only while no item is in flight.
// ----------------------------------------------------------------------------
module terrain_height_interpolator_unit #(
    parameter int MAX_COLUMNS   = 256,
    parameter int MAX_ROWS      = 256,
    parameter int FRACTION_BITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  thi_pkg::in_item_t   cmd,
    output logic                res_valid,
    input  logic                res_stall,
    output thi_pkg::out_item_t  res,
    input  logic                cfg_write,
    input  thi_pkg::cfg_index_t cfg_index,
    input  logic [15:0]         cfg_data
);
    import thi_pkg::*;

    localparam int STORE_DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int WW          = FRACTION_BITS + 1;

    // configuration registers
    logic [8:0]  cols_reg;
    logic [8:0]  cols_next;
    logic [8:0]  rows_reg;
    logic [8:0]  rows_next;
    logic [15:0] gain_reg;
    logic [15:0] gain_next;
    logic [8:0]  cols_eff;
    logic [8:0]  rows_eff;

    // locate stage
    logic        loc_valid_reg;
    logic        loc_valid_next;
    in_item_t    loc_item_reg;
    loc_flags_t  loc_flags;
    logic [ADDR_W-1:0] loc_base;
    logic [ADDR_W-1:0] loc_load_addr;
    logic [WW-1:0] loc_w0;
    logic [WW-1:0] loc_w1;
    logic [WW-1:0] loc_w2;
    logic        loc_move;
    logic        cmd_accept;

    // issue stage, owns the memory port
    logic        issue_valid_reg;
    logic        issue_valid_next;
    step_t       issue_step_reg;
    step_t       issue_step_next;
    loc_flags_t  issue_flags_reg;
    logic [ADDR_W-1:0] issue_base_reg;
    logic [ADDR_W-1:0] issue_load_addr_reg;
    logic [7:0]  issue_load_data_reg;
    logic [WW-1:0] issue_w0_reg;
    logic [WW-1:0] issue_w1_reg;
    logic [WW-1:0] issue_w2_reg;
    logic [WW-1:0] issue_weight;
    logic [ADDR_W-1:0] issue_addr;
    logic [ADDR_W-1:0] cols_a;
    logic        issue_last;
    logic        issue_go;
    logic        issue_done;
    logic        issue_free;

    // memory port
    logic        mem_en;
    logic        mem_we;
    logic [7:0]  mem_rdata;

    // read stage, lines up with the memory read data
    logic        rd_valid_reg;
    logic        rd_valid_next;
    logic        rd_read_reg;
    logic        rd_last_reg;
    logic        rd_outside_reg;
    logic [WW-1:0] rd_weight_reg;
    logic        rd_move;
    logic        rd_free;
    logic        blend_take_last;
    blend_ctl_t  blend_ctl;

    // configuration writes
    always_comb
    begin
        cols_next = cols_reg;
        rows_next = rows_reg;
        gain_next = gain_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_COLUMNS: cols_next = cfg_data[8:0];
                CFG_ROWS:    rows_next = cfg_data[8:0];
                CFG_GAIN:    gain_next = cfg_data;
                default:     ;
            endcase
        end
    end

    // grid size saturates to what the store can hold
    always_comb
    begin
        cols_eff = cols_reg;
        rows_eff = rows_reg;
        if (32'(cols_reg) > MAX_COLUMNS)
        begin
            cols_eff = 9'(MAX_COLUMNS);
        end
        if (32'(rows_reg) > MAX_ROWS)
        begin
            rows_eff = 9'(MAX_ROWS);
        end
    end

    thi_locate #(
        .FRACTION_BITS (FRACTION_BITS),
        .ADDR_W        (ADDR_W),
        .STORE_DEPTH   (STORE_DEPTH)
    ) u_locate (
        .item      (loc_item_reg),
        .cols      (cols_eff),
        .rows      (rows_eff),
        .flags     (loc_flags),
        .base      (loc_base),
        .load_addr (loc_load_addr),
        .w0        (loc_w0),
        .w1        (loc_w1),
        .w2        (loc_w2)
    );

    // handshake and stage advance
    always_comb
    begin
        // loads and edge queries end at their first port step, other queries at STEP_LAST
        issue_last = issue_flags_reg.is_load || issue_flags_reg.outside ||
                     (issue_step_reg == STEP_LAST);
        // a load needs no room downstream, reads do
        issue_go   = issue_valid_reg && (issue_flags_reg.is_load || rd_free);
        issue_done = issue_go && issue_last;
        issue_free = !issue_valid_reg || issue_done;

        loc_move   = loc_valid_reg && issue_free;
        cmd_stall  = loc_valid_reg && !issue_free;
        cmd_accept = cmd_valid && !cmd_stall;

        rd_move = rd_valid_reg && (!rd_last_reg || blend_take_last);
        rd_free = !rd_valid_reg || rd_move;

        loc_valid_next   = cmd_accept || (loc_valid_reg && !loc_move);
        issue_valid_next = loc_move || (issue_valid_reg && !issue_done);
        rd_valid_next    = (issue_go && !issue_flags_reg.is_load) ||
                           (rd_valid_reg && !rd_move);

        issue_step_next = issue_step_reg;
        if (issue_done)
        begin
            issue_step_next = STEP_FIRST;
        end
        else if (issue_go)
        begin
            unique case (issue_step_reg)
                STEP_FIRST: issue_step_next = STEP_MID;
                STEP_MID:   issue_step_next = STEP_LAST;
                default:    issue_step_next = STEP_FIRST;
            endcase
        end
    end

    // corner address and weight per step
    // first: A (lower) or C (upper), mid: B one row up, last: D one column right
    always_comb
    begin
        cols_a = ADDR_W'(cols_eff);
        unique case (issue_step_reg)
            STEP_FIRST:
            begin
                issue_addr   = issue_flags_reg.lower ? issue_base_reg
                                                     : issue_base_reg - cols_a + ADDR_W'(1);
                issue_weight = issue_w0_reg;
            end
            STEP_MID:
            begin
                issue_addr   = issue_base_reg - cols_a;
                issue_weight = issue_w1_reg;
            end
            default:
            begin
                issue_addr   = issue_base_reg + ADDR_W'(1);
                issue_weight = issue_w2_reg;
            end
        endcase

        mem_we = issue_flags_reg.is_load;
        mem_en = issue_go && (issue_flags_reg.is_load ? issue_flags_reg.write_ok
                                                      : !issue_flags_reg.outside);
        if (issue_flags_reg.is_load)
        begin
            issue_addr = issue_load_addr_reg;
        end
    end

    thi_mem #(
        .ADDR_W (ADDR_W),
        .DEPTH  (STORE_DEPTH)
    ) u_mem (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (issue_addr),
        .wdata (issue_load_data_reg),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        blend_ctl.valid   = rd_move;
        blend_ctl.read    = rd_read_reg;
        blend_ctl.last    = rd_last_reg;
        blend_ctl.outside = rd_outside_reg;
    end

    thi_blend #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (blend_ctl),
        .rdata     (mem_rdata),
        .weight    (rd_weight_reg),
        .gain      (gain_reg),
        .take_last (blend_take_last),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg        <= COLUMNS_RESET;
            rows_reg        <= ROWS_RESET;
            gain_reg        <= GAIN_RESET;
            loc_valid_reg   <= 1'b0;
            issue_valid_reg <= 1'b0;
            issue_step_reg  <= STEP_FIRST;
            rd_valid_reg    <= 1'b0;
        end
        else
        begin
            cols_reg        <= cols_next;
            rows_reg        <= rows_next;
            gain_reg        <= gain_next;
            loc_valid_reg   <= loc_valid_next;
            issue_valid_reg <= issue_valid_next;
            issue_step_reg  <= issue_step_next;
            rd_valid_reg    <= rd_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            loc_item_reg <= cmd;
        end
        if (loc_move)
        begin
            issue_flags_reg     <= loc_flags;
            issue_base_reg      <= loc_base;
            issue_load_addr_reg <= loc_load_addr;
            issue_load_data_reg <= loc_item_reg.sample_height;
            issue_w0_reg        <= loc_w0;
            issue_w1_reg        <= loc_w1;
            issue_w2_reg        <= loc_w2;
        end
        if (issue_go && !issue_flags_reg.is_load)
        begin
            rd_read_reg    <= !issue_flags_reg.outside;
            rd_last_reg    <= issue_last;
            rd_outside_reg <= issue_flags_reg.outside;
            rd_weight_reg  <= issue_weight;
        end
    end

    // read data held in the read stage must not be overwritten by a new read
    a_rdata_held: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg && !rd_move |-> !(mem_en && !mem_we))
        else $error("memory read issued while read stage is stalled");

    // a load never waits on the port
    a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        issue_valid_reg && issue_flags_reg.is_load |-> issue_done)
        else $error("load item held in issue stage");

    // an item without reads is a single step
    a_noread_last: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg && !rd_read_reg |-> rd_last_reg)
        else $error("edge query spans more than one step");

    // a read tag appearing fresh was matched by a memory read in the previous cycle
    a_tag_has_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rd_valid_reg) && rd_read_reg |-> $past(mem_en && !mem_we))
        else $error("read stage valid without a memory read");

endmodule
